// ===== src/rcfv_pkg.sv =====
// Shared types and constants for the radio-control frame validity filter.
package rcfv_pkg;

  localparam int RCFV_HIST_LEN = 16;
  localparam int RCFV_NEUTRAL  = 6000;
  localparam int PW_W          = 16;
  localparam int THR_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [PW_W-1:0]  LOW_LIMIT_RST  = 16'd3800;
  localparam logic [PW_W-1:0]  HIGH_LIMIT_RST = 16'd8200;
  localparam logic [PW_W-1:0]  MAX_STEP_RST   = 16'd1000;
  localparam logic [THR_W-1:0] LOST_THR_RST   = 5'd6;

  typedef logic [PW_W-1:0] pw_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT  = 2'd0,
    REG_HIGH_LIMIT = 2'd1,
    REG_MAX_STEP   = 2'd2,
    REG_LOST_THR   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    pw_t              low_limit;
    pw_t              high_limit;
    pw_t              max_step;
    logic [THR_W-1:0] lost_thr;
  } cfg_t;

  // Per-frame state other than the invalid-mark history
  typedef struct packed {
    pw_t  prev_dir;
    pw_t  held_dir;
    pw_t  held_speed;
    logic lost;
  } hold_t;

  typedef struct packed {
    logic frame_valid;
    pw_t  dir_out;
    pw_t  speed_out;
    logic contact_lost;
    logic contact_changed;
  } result_t;

endpackage

// ===== src/rcfv_if.sv =====
// Handshake channel interfaces: frame input, result output and register writes.
interface rcfv_in_if;
  import rcfv_pkg::*;
  logic valid;
  logic ready;
  pw_t  dir_in;
  pw_t  speed_in;
  modport source (output valid, output dir_in, output speed_in, input ready);
  modport sink   (input valid, input dir_in, input speed_in, output ready);
endinterface

interface rcfv_out_if;
  import rcfv_pkg::*;
  logic valid;
  logic ready;
  logic frame_valid;
  pw_t  dir_out;
  pw_t  speed_out;
  logic contact_lost;
  logic contact_changed;
  modport source (output valid, output frame_valid, output dir_out, output speed_out,
                  output contact_lost, output contact_changed, input ready);
  modport sink   (input valid, input frame_valid, input dir_out, input speed_out,
                  input contact_lost, input contact_changed, output ready);
endinterface

interface rcfv_cfg_if;
  import rcfv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== src/rcfv_eval.sv =====
// Frame checks, history update, contact decision and averaging for one frame.
module rcfv_eval #(
  parameter int HISTORY_LENGTH = rcfv_pkg::RCFV_HIST_LEN
) (
  input  rcfv_pkg::cfg_t              cfg,
  input  rcfv_pkg::hold_t             hold,
  input  logic [HISTORY_LENGTH-1:0]   hist,
  input  rcfv_pkg::pw_t               dir,
  input  rcfv_pkg::pw_t               speed,
  output rcfv_pkg::result_t           res,
  output rcfv_pkg::hold_t             hold_nxt,
  output logic [HISTORY_LENGTH-1:0]   hist_nxt
);
  import rcfv_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_LENGTH + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  pw_t              diff;
  logic             ok;
  logic [CNT_W-1:0] ones;
  logic             lost_nxt;
  logic [PW_W:0]    dir_sum;
  logic [PW_W:0]    speed_sum;

  always_comb begin
    diff = (hold.prev_dir >= dir) ? (hold.prev_dir - dir) : (dir - hold.prev_dir);
    ok   = (diff <= cfg.max_step)
        && (dir   >= cfg.low_limit) && (dir   <= cfg.high_limit)
        && (speed >= cfg.low_limit) && (speed <= cfg.high_limit);
  end

  // Shift in the new invalid mark, newest in bit 0
  assign hist_nxt = HISTORY_LENGTH'({hist, ~ok});

  always_comb begin
    ones = '0;
    for (int i = 0; i < HISTORY_LENGTH; i++) begin
      ones = ones + CNT_W'(hist_nxt[i]);
    end
  end

  assign lost_nxt  = CMP_W'(ones) >= CMP_W'(cfg.lost_thr);
  assign dir_sum   = {1'b0, hold.held_dir}   + {1'b0, dir};
  assign speed_sum = {1'b0, hold.held_speed} + {1'b0, speed};

  always_comb begin
    res.frame_valid     = ok;
    res.dir_out         = ok ? dir_sum[PW_W:1]   : '0;
    res.speed_out       = ok ? speed_sum[PW_W:1] : '0;
    res.contact_lost    = lost_nxt;
    res.contact_changed = lost_nxt ^ hold.lost;

    hold_nxt.prev_dir   = dir;
    hold_nxt.held_dir   = ok ? dir   : hold.held_dir;
    hold_nxt.held_speed = ok ? speed : hold.held_speed;
    hold_nxt.lost       = lost_nxt;
  end

endmodule

// ===== src/rc_frame_validity_filter.sv =====
// Radio-control frame validity filter: top level with input and result registers.
//
// Usage:
//   in_ch  carries one frame (dir_in, speed_in) per item; valid/ready handshake.
//   out_ch carries one result per frame: frame_valid, averaged dir_out and
//          speed_out (zero on an invalid frame), contact_lost and contact_changed.
//   cfg_ch writes limit registers by index (0 low limit, 1 high limit, 2 max step,
//          3 lost threshold); always ready, write only while no frame is in flight.
// Flow: a frame accepted on in_ch is registered on input, evaluated there and
//   shown on out_ch once it moves into the result register, which it does only
//   while the result register is empty or its result is being taken.
// Throughput: one frame per cycle while out_ch.ready stays high; the evaluation
//   is a single short pass between the input register and the result register,
//   with the frame state updated as each frame moves into the result register.
// Stall: while out_ch.ready is low the result holds; one more frame waits in the
//   input register, then in_ch.ready drops until the result is taken.
// Reset (synchronous, rst_n low): registers return to their defaults, directions
//   and held values to the neutral position, history and contact state clear,
//   both pipeline stages empty.
module rc_frame_validity_filter #(
  parameter int HISTORY_LENGTH   = rcfv_pkg::RCFV_HIST_LEN,
  parameter int NEUTRAL_POSITION = rcfv_pkg::RCFV_NEUTRAL
) (
  input  logic        clk,
  input  logic        rst_n,
  rcfv_in_if.sink     in_ch,
  rcfv_out_if.source  out_ch,
  rcfv_cfg_if.sink    cfg_ch
);
  import rcfv_pkg::*;

  localparam pw_t NEUTRAL = PW_W'(NEUTRAL_POSITION);

  cfg_t                      cfg_r;
  hold_t                     hold_r, hold_nxt;
  logic [HISTORY_LENGTH-1:0] hist_r, hist_nxt;
  result_t                   res, res_r;
  logic                      s1_vld_r, out_vld_r;
  pw_t                       s1_dir_r, s1_speed_r;
  logic                      out_free, adv, in_acc;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign adv         = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit  <= LOW_LIMIT_RST;
      cfg_r.high_limit <= HIGH_LIMIT_RST;
      cfg_r.max_step   <= MAX_STEP_RST;
      cfg_r.lost_thr   <= LOST_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.reg_index))
        REG_LOW_LIMIT:  cfg_r.low_limit  <= cfg_ch.wdata;
        REG_HIGH_LIMIT: cfg_r.high_limit <= cfg_ch.wdata;
        REG_MAX_STEP:   cfg_r.max_step   <= cfg_ch.wdata;
        REG_LOST_THR:   cfg_r.lost_thr   <= cfg_ch.wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  rcfv_eval #(
    .HISTORY_LENGTH (HISTORY_LENGTH)
  ) u_eval (
    .cfg      (cfg_r),
    .hold     (hold_r),
    .hist     (hist_r),
    .dir      (s1_dir_r),
    .speed    (s1_speed_r),
    .res      (res),
    .hold_nxt (hold_nxt),
    .hist_nxt (hist_nxt)
  );

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      hold_r.prev_dir   <= NEUTRAL;
      hold_r.held_dir   <= NEUTRAL;
      hold_r.held_speed <= NEUTRAL;
      hold_r.lost       <= 1'b0;
      hist_r            <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        hold_r    <= hold_nxt;
        hist_r    <= hist_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dir_r   <= in_ch.dir_in;
      s1_speed_r <= in_ch.speed_in;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.frame_valid     = res_r.frame_valid;
  assign out_ch.dir_out         = res_r.dir_out;
  assign out_ch.speed_out       = res_r.speed_out;
  assign out_ch.contact_lost    = res_r.contact_lost;
  assign out_ch.contact_changed = res_r.contact_changed;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.frame_valid |-> res_r.dir_out == '0 && res_r.speed_out == '0)
    else $error("invalid frame result carries non-zero values");

  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res.frame_valid |=> $stable(hold_r.held_dir) && $stable(hold_r.held_speed))
    else $error("held frame replaced by an invalid frame");

  a_lost_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.contact_lost == hold_r.lost)
    else $error("shown contact state differs from stored state");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_free |=> s1_vld_r && $stable(s1_dir_r) && $stable(s1_speed_r))
    else $error("waiting frame lost from input register");

endmodule

// ===== tb/sv/rc_frame_validity_filter_tb.sv =====
// Self-checking testbench for the radio-control frame validity filter.
`timescale 1ns / 100ps

module rc_frame_validity_filter_tb;
  import rcfv_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  rcfv_in_if  in_ch ();
  rcfv_out_if out_ch ();
  rcfv_cfg_if cfg_ch ();

  rc_frame_validity_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Filter state as the testbench tracks it
  cfg_t                   lim;
  pw_t                    trk_prev_dir;
  pw_t                    trk_held_dir;
  pw_t                    trk_held_speed;
  logic [RCFV_HIST_LEN-1:0] trk_hist;
  logic                   trk_lost;

  result_t pending_results[$];
  int      fail_count;
  int      burst_left;
  int      walk_dir;

  function automatic void reset_tracking();
    lim.low_limit  = LOW_LIMIT_RST;
    lim.high_limit = HIGH_LIMIT_RST;
    lim.max_step   = MAX_STEP_RST;
    lim.lost_thr   = LOST_THR_RST;
    trk_prev_dir   = pw_t'(RCFV_NEUTRAL);
    trk_held_dir   = pw_t'(RCFV_NEUTRAL);
    trk_held_speed = pw_t'(RCFV_NEUTRAL);
    trk_hist       = '0;
    trk_lost       = 1'b0;
  endfunction

  // Judge one frame, advance the tracked state and return the result it must give
  function automatic result_t filter_frame(pw_t d, pw_t s);
    result_t    r;
    pw_t        step;
    logic       ok;
    logic       now_lost;
    logic [PW_W:0] sum;
    step = (trk_prev_dir >= d) ? trk_prev_dir - d : d - trk_prev_dir;
    ok = (step <= lim.max_step) &&
         (d >= lim.low_limit) && (d <= lim.high_limit) &&
         (s >= lim.low_limit) && (s <= lim.high_limit);
    trk_prev_dir = d;
    trk_hist = {trk_hist[RCFV_HIST_LEN-2:0], ~ok};
    now_lost = ($countones(trk_hist) >= int'(lim.lost_thr));
    r.frame_valid     = ok;
    r.contact_lost    = now_lost;
    r.contact_changed = (now_lost != trk_lost);
    trk_lost = now_lost;
    if (ok) begin
      sum = {1'b0, trk_held_dir} + {1'b0, d};
      r.dir_out = sum[PW_W:1];
      sum = {1'b0, trk_held_speed} + {1'b0, s};
      r.speed_out = sum[PW_W:1];
      trk_held_dir   = d;
      trk_held_speed = s;
    end else begin
      r.dir_out   = '0;
      r.speed_out = '0;
    end
    return r;
  endfunction

  function automatic void flag_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Track register writes and frames, and check every result taken
  always @(posedge clk) begin : result_monitor
    result_t want;
    result_t seen;
    if (!rst_n) begin
      reset_tracking();
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.reg_index))
          REG_LOW_LIMIT:  lim.low_limit  = cfg_ch.wdata;
          REG_HIGH_LIMIT: lim.high_limit = cfg_ch.wdata;
          REG_MAX_STEP:   lim.max_step   = cfg_ch.wdata;
          REG_LOST_THR:   lim.lost_thr   = cfg_ch.wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(filter_frame(in_ch.dir_in, in_ch.speed_in));
      if (out_ch.valid && out_ch.ready) begin
        seen.frame_valid     = out_ch.frame_valid;
        seen.dir_out         = out_ch.dir_out;
        seen.speed_out       = out_ch.speed_out;
        seen.contact_lost    = out_ch.contact_lost;
        seen.contact_changed = out_ch.contact_changed;
        if (pending_results.size() == 0) begin
          fail_count++;
          $error("result with no frame outstanding");
        end else begin
          want = pending_results.pop_front();
          flag_field("frame_valid", int'(want.frame_valid), int'(seen.frame_valid));
          flag_field("dir_out", int'(want.dir_out), int'(seen.dir_out));
          flag_field("speed_out", int'(want.speed_out), int'(seen.speed_out));
          flag_field("contact_lost", int'(want.contact_lost), int'(seen.contact_lost));
          flag_field("contact_changed", int'(want.contact_changed),
                     int'(seen.contact_changed));
        end
      end
    end
  end

  // Receiver: stall pattern changes mode every so often
  initial begin : result_receiver
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= (tick % 12 == 0);
      endcase
    end
  end

  // Hold valid across a burst; drop it for a random gap between some bursts
  task automatic send_frame(input pw_t d, input pw_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.dir_in   <= d;
    in_ch.speed_in <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      fail_count++;
      $error("results still outstanding: %0d", pending_results.size());
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_limits(input pw_t lo, input pw_t hi, input pw_t step_max,
                            input logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_MAX_STEP, step_max);
    write_reg(REG_LOST_THR, thr);
  endtask

  // Range, step and contact loss and recovery under the reset limits
  task automatic test_default_limits();
    send_frame(16'd6000, 16'd6000);
    send_frame(16'd7000, 16'd3800);
    send_frame(16'd8000, 16'd8200);
    send_frame(16'd8200, 16'd3799);
    send_frame(16'd7200, 16'd8201);
    send_frame(16'd6199, 16'd6000);
    send_frame(16'd0, 16'd0);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd3799, 16'd6000);
    // valid walk until enough invalid marks leave the history for contact to recover
    for (int i = 0; i < 12; i++)
      send_frame(pw_t'(4400 + i * 333), pw_t'(8200 - i * 371));
    drain();
  endtask

  // With low above high no frame can pass
  task automatic test_crossed_limits();
    set_limits(16'd8200, 16'd3800, 16'hFFFF, 16'd6);
    send_frame(16'd6000, 16'd6000);
    send_frame(16'd8200, 16'd3800);
    send_frame(16'd3800, 16'd8200);
    send_frame(pw_t'($urandom), pw_t'($urandom));
    drain();
  endtask

  task automatic test_step_extremes();
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'd6);
    send_frame(16'd5000, 16'd0);
    send_frame(16'd5000, 16'hFFFF);
    send_frame(16'd5001, 16'd100);
    send_frame(16'd5001, 16'd100);
    drain();
    write_reg(REG_MAX_STEP, 16'hFFFF);
    send_frame(16'd0, 16'd1);
    send_frame(16'hFFFF, 16'hFFFE);
    send_frame(16'd0, 16'd0);
    drain();
  endtask

  task automatic test_threshold_extremes();
    set_limits(16'd3800, 16'd8200, 16'd1000, 16'd0);
    send_frame(16'd6000, 16'd6000);
    send_frame(16'd6100, 16'd6100);
    drain();
    write_reg(REG_LOST_THR, 16'd16);
    for (int i = 0; i < 18; i++) send_frame(16'd0, 16'd0);
    drain();
    write_reg(REG_LOST_THR, 16'd31);
    for (int i = 0; i < 4; i++) send_frame(16'hFFFF, 16'd0);
    drain();
    write_reg(REG_LOST_THR, 16'd1);
    send_frame(16'd6000, 16'd6000);
    for (int i = 0; i < 17; i++) send_frame(16'd6000, 16'd6000);
    drain();
  endtask

  function automatic pw_t in_range(int lo, int hi);
    if (hi < lo) return pw_t'($urandom);
    return pw_t'($urandom_range(hi, lo));
  endfunction

  // Well-formed walks inside the limits, mixed with broken frames at about bad_pct percent
  task automatic random_frames(input int n, input int bad_pct);
    int lo, hi, stp, nd, kind;
    lo = int'(lim.low_limit);
    hi = int'(lim.high_limit);
    stp = int'(lim.max_step);
    if (walk_dir < lo || walk_dir > hi) walk_dir = int'(in_range(lo, hi));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < bad_pct) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: send_frame(pw_t'($urandom), pw_t'($urandom));
          1: send_frame(pw_t'(walk_dir), pw_t'((lo > 0) ? lo - 1 : 65535));
          2: send_frame(pw_t'((hi < 65535) ? hi + 1 : 0), in_range(lo, hi));
          default: begin
            nd = walk_dir + stp + 1;
            if (nd > 65535) nd = walk_dir - stp - 1;
            if (nd < 0) nd = $urandom_range(0, 65535);
            send_frame(pw_t'(nd), in_range(lo, hi));
            walk_dir = nd;
          end
        endcase
        if (kind == 0 || kind == 2) walk_dir = int'(in_range(lo, hi));
      end else begin
        nd = walk_dir + $urandom_range(0, stp) * ($urandom_range(0, 1) ? 1 : -1);
        if (nd < lo) nd = lo;
        if (nd > hi) nd = hi;
        if (hi < lo) nd = $urandom_range(0, 65535);
        walk_dir = nd;
        send_frame(pw_t'(nd), in_range(lo, hi));
      end
    end
  endtask

  // Random phases under a spread of limit settings
  task automatic test_random_phases();
    int lo, hi, stp, thr;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin lo = 3800; hi = 8200; end
        1: begin lo = 0; hi = 65535; end
        2: begin lo = $urandom_range(0, 60000); hi = lo + $urandom_range(0, 5535); end
        default: begin lo = $urandom_range(60000, 65535); hi = 65535; end
      endcase
      case ($urandom_range(0, 4))
        0: stp = 0;
        1: stp = 65535;
        default: stp = $urandom_range(1, 4000);
      endcase
      thr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 10);
      set_limits(pw_t'(lo), pw_t'(hi), pw_t'(stp), 16'(thr));
      random_frames(150, $urandom_range(5, 60));
      drain();
    end
  endtask

  initial begin
    fail_count = 0;
    burst_left = 0;
    walk_dir   = RCFV_NEUTRAL;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.dir_in     <= '0;
    in_ch.speed_in   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_LOW_LIMIT;
    cfg_ch.wdata     <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_limits();
    test_crossed_limits();
    test_step_extremes();
    test_threshold_extremes();
    test_random_phases();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
